/* design/assert_macros.svh */
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset as disable
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");

// a signal holds its value in the cycle after a condition
`define ASSERT_HOLD(lbl, clk, rstn, cond, sig) \
	`ASSERT_CLK(lbl, clk, rstn, (cond) |=> $stable(sig))

`endif

/* design/tcb_pkg.sv */
// shared types and constants for the triangle cover and blend block
`default_nettype none

package tcb_pkg;

	// field widths
	localparam int unsigned COORD_W     = 8;
	localparam int unsigned CHAN_W      = 8;
	localparam int unsigned COLOR_W     = 24;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 24;
	localparam int unsigned IN_DATA_W   = 40;
	localparam int unsigned OUT_DATA_W  = 24;

	// frame limits
	localparam int unsigned MAX_WIDTH   = 256;
	localparam int unsigned MAX_HEIGHT  = 256;
	localparam int unsigned FRAME_CMP_W = 13;

	// arithmetic widths of the edge functions
	localparam int unsigned DIFF_W = COORD_W + 1;
	localparam int unsigned PROD_W = 2 * DIFF_W;
	localparam int unsigned AREA_W = PROD_W + 1;
	localparam int unsigned EDGE_W = PROD_W + 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTEX0_X   = 3'd0,
		REG_VERTEX0_Y   = 3'd1,
		REG_VERTEX1_X   = 3'd2,
		REG_VERTEX1_Y   = 3'd3,
		REG_VERTEX2_X   = 3'd4,
		REG_VERTEX2_Y   = 3'd5,
		REG_BLEND_COLOR = 3'd6
	} cfg_reg_t;

	// triangle vertices as configured
	typedef struct packed {
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y2;
	} triangle_t;

endpackage

`default_nettype wire

/* design/tcb_coverage.sv */
// edge function coverage test: products stage then sign and sum compare
`default_nettype none

module tcb_coverage (
	input  wire logic                         clk,
	input  wire logic                         load,
	input  wire logic [tcb_pkg::COORD_W-1:0]  px,
	input  wire logic [tcb_pkg::COORD_W-1:0]  py,
	input  wire tcb_pkg::triangle_t           tri_cfg,
	output logic                              covered
);

	// signed views of coordinates
	logic signed [tcb_pkg::DIFF_W-1:0] px_sv, py_sv;
	logic signed [tcb_pkg::DIFF_W-1:0] x0_sv, y0_sv, x1_sv, y1_sv, x2_sv, y2_sv;
	logic signed [tcb_pkg::DIFF_W-1:0] dy20, dx02, dy01, dx10, dx20, dy10;
	logic signed [tcb_pkg::PROD_W-1:0] ex0, ey0, ex1, ey1, da, db;
	logic [2*tcb_pkg::COORD_W-1:0]     pa, pb, pc, pd;
	logic [tcb_pkg::COORD_W-1:0]       lo_x, hi_x, lo_y, hi_y;
	logic                              in_frame, in_box;

	// stage 2 registers
	logic signed [tcb_pkg::PROD_W-1:0] ex0_s2, ey0_s2, ex1_s2, ey1_s2, cs_s2, ct_s2;
	logic signed [tcb_pkg::AREA_W-1:0] d_s2;
	logic                              in_box_s2;

	// stage 2 evaluation
	logic signed [tcb_pkg::EDGE_W-1:0] s_val, t_val, st_val, d_ext;
	logic                              neg;

	assign px_sv = signed'({1'b0, px});
	assign py_sv = signed'({1'b0, py});
	assign x0_sv = signed'({1'b0, tri_cfg.x0});
	assign y0_sv = signed'({1'b0, tri_cfg.y0});
	assign x1_sv = signed'({1'b0, tri_cfg.x1});
	assign y1_sv = signed'({1'b0, tri_cfg.y1});
	assign x2_sv = signed'({1'b0, tri_cfg.x2});
	assign y2_sv = signed'({1'b0, tri_cfg.y2});

	// vertex differences
	assign dy20 = y2_sv - y0_sv;
	assign dx02 = x0_sv - x2_sv;
	assign dy01 = y0_sv - y1_sv;
	assign dx10 = x1_sv - x0_sv;
	assign dx20 = x2_sv - x0_sv;
	assign dy10 = y1_sv - y0_sv;

	// parallel products, one level deep
	assign ex0 = dy20 * px_sv;
	assign ey0 = dx02 * py_sv;
	assign ex1 = dy01 * px_sv;
	assign ey1 = dx10 * py_sv;
	assign da  = dx10 * dy20;
	assign db  = dx20 * dy10;
	assign pa  = tri_cfg.y0 * tri_cfg.x2;
	assign pb  = tri_cfg.x0 * tri_cfg.y2;
	assign pc  = tri_cfg.x0 * tri_cfg.y1;
	assign pd  = tri_cfg.y0 * tri_cfg.x1;

	// bounding box of the vertices
	always_comb begin
		lo_x = tri_cfg.x0;
		hi_x = tri_cfg.x0;
		lo_y = tri_cfg.y0;
		hi_y = tri_cfg.y0;
		if (tri_cfg.x1 < lo_x) lo_x = tri_cfg.x1;
		if (tri_cfg.x2 < lo_x) lo_x = tri_cfg.x2;
		if (tri_cfg.x1 > hi_x) hi_x = tri_cfg.x1;
		if (tri_cfg.x2 > hi_x) hi_x = tri_cfg.x2;
		if (tri_cfg.y1 < lo_y) lo_y = tri_cfg.y1;
		if (tri_cfg.y2 < lo_y) lo_y = tri_cfg.y2;
		if (tri_cfg.y1 > hi_y) hi_y = tri_cfg.y1;
		if (tri_cfg.y2 > hi_y) hi_y = tri_cfg.y2;
	end

	// half-open box and frame limits
	assign in_frame = ({{(tcb_pkg::FRAME_CMP_W-tcb_pkg::COORD_W){1'b0}}, px}
	                   < tcb_pkg::FRAME_CMP_W'(tcb_pkg::MAX_WIDTH))
	               && ({{(tcb_pkg::FRAME_CMP_W-tcb_pkg::COORD_W){1'b0}}, py}
	                   < tcb_pkg::FRAME_CMP_W'(tcb_pkg::MAX_HEIGHT));
	assign in_box   = in_frame && (px >= lo_x) && (px < hi_x) && (py >= lo_y) && (py < hi_y);

	// products register
	always_ff @(posedge clk) begin
		if (load) begin
			ex0_s2    <= ex0;
			ey0_s2    <= ey0;
			ex1_s2    <= ex1;
			ey1_s2    <= ey1;
			cs_s2     <= signed'({2'b00, pa}) - signed'({2'b00, pb});
			ct_s2     <= signed'({2'b00, pc}) - signed'({2'b00, pd});
			d_s2      <= {da[tcb_pkg::PROD_W-1], da} - {db[tcb_pkg::PROD_W-1], db};
			in_box_s2 <= in_box;
		end
	end

	// edge sums and sign-aware compare
	assign s_val  = {{2{cs_s2[tcb_pkg::PROD_W-1]}}, cs_s2}
	              + {{2{ex0_s2[tcb_pkg::PROD_W-1]}}, ex0_s2}
	              + {{2{ey0_s2[tcb_pkg::PROD_W-1]}}, ey0_s2};
	assign t_val  = {{2{ct_s2[tcb_pkg::PROD_W-1]}}, ct_s2}
	              + {{2{ex1_s2[tcb_pkg::PROD_W-1]}}, ex1_s2}
	              + {{2{ey1_s2[tcb_pkg::PROD_W-1]}}, ey1_s2};
	assign st_val = s_val + t_val;
	assign d_ext  = {d_s2[tcb_pkg::AREA_W-1], d_s2};
	assign neg    = d_s2[tcb_pkg::AREA_W-1];

	always_comb begin
		if (neg) begin
			covered = in_box_s2
			       && (s_val[tcb_pkg::EDGE_W-1] || (s_val == '0))
			       && (t_val[tcb_pkg::EDGE_W-1] || (t_val == '0))
			       && (st_val >= d_ext);
		end else begin
			covered = in_box_s2
			       && !s_val[tcb_pkg::EDGE_W-1]
			       && !t_val[tcb_pkg::EDGE_W-1]
			       && (st_val <= d_ext);
		end
	end

endmodule

`default_nettype wire

/* design/triangle_cover_and_blend.sv */
// Triangle cover and blend: one pixel per clock in, one pixel per clock out while the
// output is not stalled. Each pixel passes three registers (input, edge-function products,
// result); the pipeline takes a new pixel every cycle unless m_axis_tready holds it back.
// s_axis_tready follows m_axis_tready combinationally through the stage valids, so a
// stalled result holds in the output register while earlier stages keep filling. The user
// must write vertex and color registers through the cfg port only while no pixel is in
// flight; the block itself does not enforce this.
`default_nettype none

module triangle_cover_and_blend (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_write,
	input  wire logic [tcb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tcb_pkg::CFG_DATA_W-1:0]  cfg_data,
	// pixel in
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue
	input  wire logic [tcb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// pixel out
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// out_red, out_green, out_blue
	output logic [tcb_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// covered
	output logic                                 m_axis_tuser
);

	localparam int unsigned CW = tcb_pkg::CHAN_W;

	tcb_pkg::triangle_t          tri_q;
	logic [tcb_pkg::COLOR_W-1:0] blend_color_q;

	logic                        valid_s1, valid_s2, valid_s3;
	logic                        adv1, adv2, adv3;
	logic [tcb_pkg::COORD_W-1:0] x_s1, y_s1;
	logic [CW-1:0]               red_s1, green_s1, blue_s1;
	logic [CW-1:0]               red_s2, green_s2, blue_s2;
	logic [CW-1:0]               out_red_s3, out_green_s3, out_blue_s3;
	logic                        covered_s3;
	logic                        covered;
	logic [CW:0]                 sum_red, sum_green, sum_blue;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_q         <= '0;
			blend_color_q <= '0;
		end else if (cfg_write) begin
			unique case (tcb_pkg::cfg_reg_t'(cfg_index))
				tcb_pkg::REG_VERTEX0_X:   tri_q.x0 <= cfg_data[tcb_pkg::COORD_W-1:0];
				tcb_pkg::REG_VERTEX0_Y:   tri_q.y0 <= cfg_data[tcb_pkg::COORD_W-1:0];
				tcb_pkg::REG_VERTEX1_X:   tri_q.x1 <= cfg_data[tcb_pkg::COORD_W-1:0];
				tcb_pkg::REG_VERTEX1_Y:   tri_q.y1 <= cfg_data[tcb_pkg::COORD_W-1:0];
				tcb_pkg::REG_VERTEX2_X:   tri_q.x2 <= cfg_data[tcb_pkg::COORD_W-1:0];
				tcb_pkg::REG_VERTEX2_Y:   tri_q.y2 <= cfg_data[tcb_pkg::COORD_W-1:0];
				tcb_pkg::REG_BLEND_COLOR: blend_color_q <= cfg_data[tcb_pkg::COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// stage advance: a stage loads when it is empty or the next one loads
	assign adv3          = !valid_s3 || m_axis_tready;
	assign adv2          = !valid_s2 || adv3;
	assign adv1          = !valid_s1 || adv2;
	assign s_axis_tready = adv1;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= s_axis_tvalid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv1) begin
			x_s1     <= s_axis_tdata[7:0];
			y_s1     <= s_axis_tdata[15:8];
			red_s1   <= s_axis_tdata[23:16];
			green_s1 <= s_axis_tdata[31:24];
			blue_s1  <= s_axis_tdata[39:32];
		end
	end

	// coverage test across stages 1 and 2
	tcb_coverage u_coverage (
		.clk     (clk),
		.load    (adv2),
		.px      (x_s1),
		.py      (y_s1),
		.tri_cfg (tri_q),
		.covered (covered)
	);

	// color carried alongside the products
	always_ff @(posedge clk) begin
		if (adv2) begin
			red_s2   <= red_s1;
			green_s2 <= green_s1;
			blue_s2  <= blue_s1;
		end
	end

	// channel averages with the fill color
	assign sum_red   = {1'b0, red_s2}   + {1'b0, blend_color_q[23:16]};
	assign sum_green = {1'b0, green_s2} + {1'b0, blend_color_q[15:8]};
	assign sum_blue  = {1'b0, blue_s2}  + {1'b0, blend_color_q[7:0]};

	// result register
	always_ff @(posedge clk) begin
		if (adv3) begin
			covered_s3   <= covered;
			out_red_s3   <= covered ? sum_red[CW:1]   : red_s2;
			out_green_s3 <= covered ? sum_green[CW:1] : green_s2;
			out_blue_s3  <= covered ? sum_blue[CW:1]  : blue_s2;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {out_blue_s3, out_green_s3, out_red_s3};
	assign m_axis_tuser  = covered_s3;

endmodule

`default_nettype wire

/* design/tcb_checker.sv */
// port-level checker for the triangle cover and blend block, with its bind
`default_nettype none
`include "assert_macros.svh"

module tcb_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [tcb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input wire logic                            m_axis_tuser
);

	// a stalled result keeps its data and flag
	`ASSERT_HOLD(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		({m_axis_tdata, m_axis_tuser}))

	// an empty or draining output register never blocks the input
	`ASSERT_CLK(a_ready_flow, clk, arst_n, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)

	// with no stall, an accepted pixel reaches the output through the input, products and result registers
	`ASSERT_CLK(a_latency, clk, arst_n,
		($past(s_axis_tvalid && s_axis_tready, 3) && $past(arst_n, 3) && $past(arst_n, 2)
		&& $past(arst_n, 1) && $past(m_axis_tready, 2) && $past(m_axis_tready, 1))
		|-> m_axis_tvalid)

endmodule

bind triangle_cover_and_blend tcb_checker u_tcb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
